[rtl/core/grid_ray_march_with_mirrors_top_assert.svh]
// assertion macros for the grid ray march block
`ifndef GRID_RAY_MARCH_WITH_MIRRORS_TOP_ASSERT_SVH
`define GRID_RAY_MARCH_WITH_MIRRORS_TOP_ASSERT_SVH

// same-cycle implication, checked at every rising edge outside reset
`define GRMM_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("grid ray march check failed");

// next-cycle implication
`define GRMM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("grid ray march check failed");

`endif

[rtl/core/grmm_pkg.sv]
// shared types and constants of the grid ray march block
`timescale 1ns / 1ps
`default_nettype none

package grmm_pkg;

  // fixed-point layout
  localparam int FRAC_BITS   = 14;
  localparam int POS_W       = 26;
  localparam int CELL_W      = POS_W - FRAC_BITS;
  localparam int DIR_W       = 17;
  localparam int CELL_DATA_W = 5;

  // stream payload widths
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 16;

  // defaults
  localparam int        DEF_GRID_SIDE    = 64;
  localparam logic [7:0] DEF_MAX_STEPS    = 8'd80;
  localparam logic [2:0] DEF_PLAYER_COLOR = 3'd0;
  localparam logic [7:0] DEF_SHADE_STEP   = 8'd5;
  localparam logic [3:0] SHADE_MAX        = 4'd9;

  // command codes carried in tuser
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_CAST  = 1'b1;

  // stored cell types
  typedef enum logic [1:0] {
    TYPE_VOID     = 2'd0,
    TYPE_WALL     = 2'd1,
    TYPE_MIRROR   = 2'd2,
    TYPE_RESERVED = 2'd3
  } cell_type_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_MAX_STEPS    = 2'd0,
    CFG_PLAYER_COLOR = 2'd1,
    CFG_SHADE_STEP   = 2'd2
  } cfg_idx_t;

  // engine sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_EVAL,
    ST_SIDE,
    ST_DONE
  } eng_state_t;

  typedef struct packed {
    logic [7:0] max_steps;
    logic [2:0] player_color;
    logic [7:0] shade_step;
  } cfg_t;

  typedef struct packed {
    logic        cmd;
    logic [5:0]  cell_row;
    logic [5:0]  cell_col;
    logic [1:0]  cell_type;
    logic [2:0]  cell_color;
    logic [19:0] start_x;
    logic [19:0] start_y;
    logic [15:0] dir_x;
    logic [15:0] dir_y;
  } in_item_t;

  typedef struct packed {
    logic [7:0] ray_length;
    logic       hit_player;
    logic [2:0] hit_color;
    logic [3:0] shade;
  } result_t;

endpackage

`default_nettype wire

[rtl/core/grmm_map_ram.sv]
// map cell memory, one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module grmm_map_ram
  import grmm_pkg::*;
#(
  parameter int AW = 12
) (
  input  wire logic                   clk,
  input  wire logic                   wr_en,
  input  wire logic [AW-1:0]          wr_addr,
  input  wire logic [CELL_DATA_W-1:0] wr_data,
  input  wire logic                   rd_en,
  input  wire logic [AW-1:0]          rd_addr,
  output      logic [CELL_DATA_W-1:0] rd_data
);

  logic [CELL_DATA_W-1:0] mem [2**AW];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered output
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/grmm_engine.sv]
// march sequencer: clearing pass, cell writes and ray stepping over the map memory
`timescale 1ns / 1ps
`default_nettype none

module grmm_engine
  import grmm_pkg::*;
#(
  parameter int GRID_SIDE = DEF_GRID_SIDE,
  parameter int CW        = $clog2(GRID_SIDE),
  parameter int AW        = 2 * CW
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire cfg_t                   cfg,
  input  wire logic                   in_valid,
  output      logic                   in_ready,
  input  wire in_item_t               in_item,
  output      logic                   res_valid,
  input  wire logic                   res_ready,
  output      result_t                res,
  output      logic                   mem_wr_en,
  output      logic [AW-1:0]          mem_wr_addr,
  output      logic [CELL_DATA_W-1:0] mem_wr_data,
  output      logic                   mem_rd_en,
  output      logic [AW-1:0]          mem_rd_addr,
  input  wire logic [CELL_DATA_W-1:0] mem_rd_data
);

  localparam logic signed [CELL_W-1:0] SIDE_LIM = CELL_W'(GRID_SIDE);
  localparam logic [AW-1:0]            CLR_LAST = '1;

  eng_state_t state, state_next;

  logic [AW-1:0]            clr_addr;
  logic signed [POS_W-1:0]  px, py;
  logic signed [DIR_W-1:0]  dx, dy;
  logic signed [CELL_W-1:0] start_r, start_c;
  logic signed [CELL_W-1:0] nr, nc;
  logic                     next_off;
  logic                     side_off;
  logic [7:0]               steps;
  logic [7:0]               shade_cnt;
  logic [3:0]               shade;
  logic                     reflected;
  logic                     hit;
  logic [2:0]               color;

  // combinational helpers
  logic                     accept;
  logic signed [DIR_W-1:0]  dx_use, dy_use;
  logic signed [POS_W-1:0]  px_step, py_step;
  logic signed [POS_W-1:0]  look_x, look_y;
  logic signed [CELL_W-1:0] look_r, look_c;
  logic                     look_off;
  logic signed [CELL_W-1:0] cur_r, side_c;
  logic                     side_out;
  logic signed [CELL_W-1:0] wr_row, wr_col;
  cell_type_t               rd_type;
  cell_type_t               next_type;
  cell_type_t               side_type;
  logic [7:0]               sdiv;
  logic [8:0]               shade_cnt_inc;

  // control strobes
  logic ld_cast, ld_look, do_step, set_hit, set_color, set_reflect, ld_side;

  function automatic logic outside(input logic signed [CELL_W-1:0] coord);
    return (coord < 0) || (coord >= SIDE_LIM);
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic signed [CELL_W-1:0] r,
                                              input logic signed [CELL_W-1:0] c);
    return {r[CW-1:0], c[CW-1:0]};
  endfunction

  assign accept = in_valid && in_ready;

  // stored type decode, the reserved code acts as a wall
  always_comb begin
    rd_type = cell_type_t'(mem_rd_data[CELL_DATA_W-1:3]);
    if (rd_type == TYPE_RESERVED) begin
      rd_type = TYPE_WALL;
    end
    next_type = next_off ? TYPE_WALL : rd_type;
    side_type = side_off ? TYPE_WALL : rd_type;
  end

  // direction used for the step, flipped after a side lookup
  always_comb begin
    dx_use = dx;
    dy_use = dy;
    if (state == ST_SIDE) begin
      if (side_type == TYPE_MIRROR) begin
        dx_use = -dx;
      end else begin
        dy_use = -dy;
      end
    end
  end

  // position arithmetic
  always_comb begin
    px_step = px + {{(POS_W-DIR_W){dx_use[DIR_W-1]}}, dx_use};
    py_step = py + {{(POS_W-DIR_W){dy_use[DIR_W-1]}}, dy_use};
    look_x  = px + {{(POS_W-DIR_W){dx[DIR_W-1]}}, dx};
    look_y  = py + {{(POS_W-DIR_W){dy[DIR_W-1]}}, dy};
    look_c  = look_x[POS_W-1:FRAC_BITS];
    look_r  = look_y[POS_W-1:FRAC_BITS];
    look_off = outside(look_r) || outside(look_c);
    cur_r   = py[POS_W-1:FRAC_BITS];
    if (dx[DIR_W-1]) begin
      side_c = px[POS_W-1:FRAC_BITS] - CELL_W'(1);
    end else if (dx != '0) begin
      side_c = px[POS_W-1:FRAC_BITS] + CELL_W'(1);
    end else begin
      side_c = px[POS_W-1:FRAC_BITS];
    end
    side_out = outside(cur_r) || outside(side_c);
    wr_row  = CELL_W'(in_item.cell_row);
    wr_col  = CELL_W'(in_item.cell_col);
  end

  // incremental quotient of steps by the shade step
  always_comb begin
    sdiv          = (cfg.shade_step == 8'd0) ? 8'd1 : cfg.shade_step;
    shade_cnt_inc = {1'b0, shade_cnt} + 9'd1;
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and strobes
  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    res_valid   = 1'b0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = clr_addr;
    mem_wr_data = '0;
    mem_rd_en   = 1'b0;
    mem_rd_addr = cell_addr(look_r, look_c);
    ld_cast     = 1'b0;
    ld_look     = 1'b0;
    do_step     = 1'b0;
    set_hit     = 1'b0;
    set_color   = 1'b0;
    set_reflect = 1'b0;
    ld_side     = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        mem_wr_en = 1'b1;
        if (clr_addr == CLR_LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          if (in_item.cmd == CMD_CAST) begin
            ld_cast    = 1'b1;
            state_next = ST_LOOK;
          end else begin
            mem_wr_en   = !outside(wr_row) && !outside(wr_col);
            mem_wr_addr = cell_addr(wr_row, wr_col);
            mem_wr_data = {in_item.cell_type, in_item.cell_color};
          end
        end
      end
      ST_LOOK: begin
        mem_rd_en  = !look_off;
        ld_look    = 1'b1;
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        priority if (next_type == TYPE_WALL || steps >= cfg.max_steps) begin
          set_color  = 1'b1;
          state_next = ST_DONE;
        end else if (reflected && nr == start_r && nc == start_c) begin
          do_step    = 1'b1;
          set_hit    = 1'b1;
          state_next = ST_DONE;
        end else if (next_type == TYPE_MIRROR) begin
          set_reflect = 1'b1;
          ld_side     = 1'b1;
          mem_rd_en   = !side_out;
          mem_rd_addr = cell_addr(cur_r, side_c);
          state_next  = ST_SIDE;
        end else begin
          do_step    = 1'b1;
          state_next = ST_LOOK;
        end
      end
      ST_SIDE: begin
        do_step    = 1'b1;
        state_next = ST_LOOK;
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // clearing pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // ray datapath
  always_ff @(posedge clk) begin
    if (ld_cast) begin
      px        <= POS_W'(in_item.start_x);
      py        <= POS_W'(in_item.start_y);
      dx        <= {in_item.dir_x[15], in_item.dir_x};
      dy        <= {in_item.dir_y[15], in_item.dir_y};
      start_c   <= CELL_W'(in_item.start_x[19:FRAC_BITS]);
      start_r   <= CELL_W'(in_item.start_y[19:FRAC_BITS]);
      steps     <= '0;
      shade_cnt <= '0;
      shade     <= '0;
      reflected <= 1'b0;
      hit       <= 1'b0;
    end
    if (ld_look) begin
      nr       <= look_r;
      nc       <= look_c;
      next_off <= look_off;
    end
    if (ld_side) begin
      side_off <= side_out;
    end
    if (set_reflect) begin
      reflected <= 1'b1;
    end
    if (set_hit) begin
      hit <= 1'b1;
    end
    if (set_color) begin
      color <= next_off ? 3'd0 : mem_rd_data[2:0];
    end
    if (do_step) begin
      px    <= px_step;
      py    <= py_step;
      dx    <= dx_use;
      dy    <= dy_use;
      steps <= steps + 8'd1;
      if (shade_cnt_inc == {1'b0, sdiv}) begin
        shade_cnt <= '0;
        if (shade != SHADE_MAX) begin
          shade <= shade + 4'd1;
        end
      end else begin
        shade_cnt <= shade_cnt_inc[7:0];
      end
    end
  end

  // result fields
  always_comb begin
    res.ray_length = steps;
    res.hit_player = hit;
    res.hit_color  = hit ? cfg.player_color : color;
    res.shade      = shade;
  end

endmodule

`default_nettype wire

[rtl/core/grid_ray_march_with_mirrors_top.sv]
// top level of the grid ray march block: ports, registers, output stage, checks
`timescale 1ns / 1ps
`default_nettype none

// Grid ray marcher with mirrors. A write item (tuser 0) stores one map cell; a cast item
// (tuser 1) marches a ray through the map and yields one result. Each march step first
// addresses the next cell, then evaluates the read data; a step onto a mirror adds a
// side-cell lookup. A cast also passes through the accept, the final lookup that stops
// the ray and the result hand-off. The number of steps is bounded by the max_steps
// register; the single read port of the map memory sets the pace of the march. After
// reset the map is cleared one cell per cycle, all 2**(2*clog2(GRID_SIDE)) cells (4096
// at the default size), during which no item is taken; register writes are always
// taken. A finished result sits in the output register while the next item is accepted.

module grid_ray_march_with_mirrors_top
  import grmm_pkg::*;
#(
  parameter int GRID_SIDE = DEF_GRID_SIDE
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output      logic                  s_axis_tready,
  // cell_row, cell_col, cell_type, cell_color, start_x, start_y, dir_x, dir_y, zero fill
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // cmd
  input  wire logic                  s_axis_tuser,
  output      logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // ray_length, hit_player, hit_color, shade
  output      logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  wire logic                  cfg_valid,
  output      logic                  cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [7:0]            cfg_data
);

  `include "grid_ray_march_with_mirrors_top_assert.svh"

  localparam int CW = $clog2(GRID_SIDE);
  localparam int AW = 2 * CW;

  cfg_t     cfg;
  in_item_t in_item;
  result_t  res;
  result_t  out_res;
  logic     res_valid;
  logic     res_ready;
  logic     res_load;

  logic                   mem_wr_en;
  logic [AW-1:0]          mem_wr_addr;
  logic [CELL_DATA_W-1:0] mem_wr_data;
  logic                   mem_rd_en;
  logic [AW-1:0]          mem_rd_addr;
  logic [CELL_DATA_W-1:0] mem_rd_data;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_steps    <= DEF_MAX_STEPS;
      cfg.player_color <= DEF_PLAYER_COLOR;
      cfg.shade_step   <= DEF_SHADE_STEP;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MAX_STEPS:    cfg.max_steps    <= cfg_data;
        CFG_PLAYER_COLOR: cfg.player_color <= cfg_data[2:0];
        CFG_SHADE_STEP:   cfg.shade_step   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // input unpacking
  always_comb begin
    in_item.cmd        = s_axis_tuser;
    in_item.cell_row   = s_axis_tdata[5:0];
    in_item.cell_col   = s_axis_tdata[11:6];
    in_item.cell_type  = s_axis_tdata[13:12];
    in_item.cell_color = s_axis_tdata[16:14];
    in_item.start_x    = s_axis_tdata[36:17];
    in_item.start_y    = s_axis_tdata[56:37];
    in_item.dir_x      = s_axis_tdata[72:57];
    in_item.dir_y      = s_axis_tdata[88:73];
  end

  grmm_engine #(
    .GRID_SIDE (GRID_SIDE),
    .CW        (CW),
    .AW        (AW)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_item     (in_item),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  grmm_map_ram #(
    .AW (AW)
  ) u_map (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // output register, loads when empty or draining
  assign res_ready = !m_axis_tvalid || m_axis_tready;
  assign res_load  = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {out_res.shade, out_res.hit_color, out_res.hit_player,
                         out_res.ray_length};

  // checks
  `GRMM_ASSERT_IMPLIES(a_no_overwrite, clk, rst, res_load, !m_axis_tvalid || m_axis_tready)
  `GRMM_ASSERT_NEXT(a_load_shows, clk, rst, res_load, m_axis_tvalid)
  `GRMM_ASSERT_IMPLIES(a_shade_cap, clk, rst, m_axis_tvalid, out_res.shade <= SHADE_MAX)
  `GRMM_ASSERT_IMPLIES(a_hit_len, clk, rst, m_axis_tvalid && out_res.hit_player, out_res.ray_length >= 8'd2)

endmodule

`default_nettype wire

[dv/testbench.sv]
// self-checking testbench for the grid ray march block
`timescale 1ns / 1ps

module testbench;
  import grmm_pkg::*;

  localparam int GRID_SIDE = DEF_GRID_SIDE;
  localparam int ONE = 16384;      // 1.0 in Q14
  localparam int DIAG = 11585;     // about 0.7071 in Q14
  // the cycle limit leaves room many times over for 403 items, stalls, sender gaps,
  // the long hold-off and the map clear after reset
  localparam int CYCLE_LIMIT = 1500000;
  localparam int HOLD_CYCLES = 3000;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_COIN,
    RX_SPARSE,
    RX_MOSTLY
  } rx_mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // cell_row, cell_col, cell_type, cell_color, start_x, start_y, dir_x, dir_y, zero fill
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  // cmd
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // ray_length, hit_player, hit_color, shade
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [1:0]            cfg_index = '0;
  logic [7:0]            cfg_data = '0;

  // predictor state: map copy and register copy
  logic [4:0] map_store [0:GRID_SIDE*GRID_SIDE-1];
  logic [7:0] max_steps_reg;
  logic [2:0] player_color_reg;
  logic [7:0] shade_step_reg;

  in_item_t pending_items [$];
  result_t  ray_results_due [$];
  in_item_t on_bus;

  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  bit hold_request = 0;
  rx_mode_t rx_mode = RX_FREE;
  int rx_mode_left = 0;
  int cycle_count = 0;

  int mismatches = 0;
  int writes_taken = 0;
  int casts_taken = 0;
  int bounced_rays = 0;
  int player_hits = 0;
  int results_seen = 0;
  int phases_run = 0;

  grid_ray_march_with_mirrors_top uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // floor of a Q14 position
  function automatic longint cell_of(longint pos);
    return pos >>> 14;
  endfunction

  function automatic logic [19:0] cell_center(int c);
    return 20'(c * ONE + ONE / 2);
  endfunction

  // cells off the map read as a wall of color zero; reserved type is a wall
  function automatic void peek_cell(longint row, longint col, output cell_type_t kind,
                                    output logic [2:0] color);
    logic [4:0] v;
    if (row < 0 || col < 0 || row >= GRID_SIDE || col >= GRID_SIDE) begin
      kind = TYPE_WALL;
      color = 3'd0;
    end else begin
      v = map_store[int'(row) * GRID_SIDE + int'(col)];
      kind = cell_type_t'(v[4:3]);
      if (kind == TYPE_RESERVED) kind = TYPE_WALL;
      color = v[2:0];
    end
  endfunction

  // march one ray through the map copy
  function automatic result_t trace_ray(in_item_t it, output bit bounced);
    longint px, py, dx, dy, home_r, home_c, nr, nc, sgn;
    int steps;
    int divisor;
    int level;
    bit hit;
    bit done;
    cell_type_t kind, side_kind;
    logic [2:0] color, side_color;
    result_t r;
    px = longint'(it.start_x);
    py = longint'(it.start_y);
    dx = longint'($signed(it.dir_x));
    dy = longint'($signed(it.dir_y));
    home_c = cell_of(px);
    home_r = cell_of(py);
    steps = 0;
    hit = 0;
    bounced = 0;
    done = 0;
    while (!done) begin
      nr = cell_of(py + dy);
      nc = cell_of(px + dx);
      peek_cell(nr, nc, kind, color);
      if (kind == TYPE_WALL || steps >= int'(max_steps_reg)) begin
        done = 1;
      end else if (bounced && nr == home_r && nc == home_c) begin
        steps++;
        hit = 1;
        done = 1;
      end else begin
        // mirror: flip dx when the side cell is a mirror too, else flip dy
        if (kind == TYPE_MIRROR) begin
          bounced = 1;
          sgn = (dx > 0) ? 1 : ((dx < 0) ? -1 : 0);
          peek_cell(cell_of(py), cell_of(px) + sgn, side_kind, side_color);
          if (side_kind == TYPE_MIRROR) dx = -dx;
          else dy = -dy;
        end
        px += dx;
        py += dy;
        steps++;
      end
    end
    divisor = (shade_step_reg == 8'd0) ? 1 : int'(shade_step_reg);
    level = steps / divisor;
    if (level > int'(SHADE_MAX)) level = int'(SHADE_MAX);
    r.ray_length = 8'(steps);
    r.hit_player = hit;
    r.hit_color = hit ? player_color_reg : color;
    r.shade = 4'(level);
    return r;
  endfunction

  // update the predictor for one accepted input transfer
  function automatic void accept_item(in_item_t it);
    bit bounced;
    result_t r;
    if (it.cmd == CMD_WRITE) begin
      map_store[int'(it.cell_row) * GRID_SIDE + int'(it.cell_col)] =
        {it.cell_type, it.cell_color};
      writes_taken++;
    end else begin
      r = trace_ray(it, bounced);
      ray_results_due.push_back(r);
      casts_taken++;
      if (bounced) bounced_rays++;
      if (r.hit_player) player_hits++;
    end
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_item(in_item_t it);
    return {7'd0, it.dir_y, it.dir_x, it.start_y, it.start_x,
            it.cell_color, it.cell_type, it.cell_col, it.cell_row};
  endfunction

  // unused fields of each item carry random bits
  task automatic add_write(int row, int col, cell_type_t kind, int color);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom, $urandom});
    it.cmd = CMD_WRITE;
    it.cell_row = 6'(row);
    it.cell_col = 6'(col);
    it.cell_type = kind;
    it.cell_color = 3'(color);
    pending_items.push_back(it);
  endtask

  task automatic add_cast(logic [19:0] x, logic [19:0] y, int dx, int dy);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom, $urandom});
    it.cmd = CMD_CAST;
    it.start_x = x;
    it.start_y = y;
    it.dir_x = 16'(dx);
    it.dir_y = 16'(dy);
    pending_items.push_back(it);
  endtask

  // mostly local scenes inside a 16x16 window, some items fully random
  task automatic add_random_item(int r0, int c0);
    in_item_t it;
    int pick;
    int kind_pick;
    logic [19:0] x, y;
    int dx, dy;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      it = in_item_t'({$urandom, $urandom, $urandom});
      pending_items.push_back(it);
    end else if (pick < 43) begin
      kind_pick = $urandom_range(0, 99);
      add_write((r0 + $urandom_range(0, 15)) % GRID_SIDE,
                (c0 + $urandom_range(0, 15)) % GRID_SIDE,
                cell_type_t'((kind_pick < 25) ? TYPE_VOID : (kind_pick < 50) ? TYPE_WALL :
                             (kind_pick < 90) ? TYPE_MIRROR : TYPE_RESERVED),
                $urandom_range(0, 7));
    end else begin
      x = {6'((c0 + $urandom_range(0, 15)) % GRID_SIDE), 14'($urandom)};
      y = {6'((r0 + $urandom_range(0, 15)) % GRID_SIDE), 14'($urandom)};
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        dx = 0;
        dy = 0;
        if ($urandom_range(0, 1)) dx = $urandom_range(0, 1) ? ONE : -ONE;
        else dy = $urandom_range(0, 1) ? ONE : -ONE;
      end else if (pick < 6) begin
        dx = $urandom_range(0, 1) ? DIAG : -DIAG;
        dy = $urandom_range(0, 1) ? DIAG : -DIAG;
      end else if (pick < 9) begin
        dx = int'($urandom_range(0, 2 * ONE)) - ONE;
        dy = int'($urandom_range(0, 2 * ONE)) - ONE;
      end else begin
        dx = int'($urandom);
        dy = int'($urandom);
      end
      add_cast(x, y, dx, dy);
    end
  endtask

  task automatic set_reg(cfg_idx_t idx, logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MAX_STEPS:    max_steps_reg = val;
      CFG_PLAYER_COLOR: player_color_reg = val[2:0];
      CFG_SHADE_STEP:   shade_step_reg = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // all items sent, all results back, then let a trailing write settle
  task automatic wait_drained();
    @(negedge clk);
    while (pending_items.size() != 0 || s_axis_tvalid || ray_results_due.size() != 0)
      @(negedge clk);
    repeat (40) @(negedge clk);
    phases_run++;
  endtask

  // sender: bursts of random length with random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) accept_item(on_bus);
      if (gap_left != 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        on_bus = pending_items.pop_front();
        s_axis_tdata <= pack_item(on_bus);
        s_axis_tuser <= on_bus.cmd;
        s_axis_tvalid <= 1'b1;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 15);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: own stall pattern, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_request) begin
      hold_request = 0;
      hold_left = HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(20, 200);
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        RX_FREE:   m_axis_tready <= 1'b1;
        RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default:   m_axis_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin
    result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.ray_length = m_axis_tdata[7:0];
      got.hit_player = m_axis_tdata[8];
      got.hit_color = m_axis_tdata[11:9];
      got.shade = m_axis_tdata[15:12];
      results_seen++;
      if (ray_results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result len=%0d hit=%0b color=%0d shade=%0d",
                   $time, got.ray_length, got.hit_player, got.hit_color, got.shade);
      end else begin
        want = ray_results_due.pop_front();
        if (got.ray_length !== want.ray_length || got.hit_player !== want.hit_player ||
            got.hit_color !== want.hit_color || got.shade !== want.shade) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result %0d exp len=%0d hit=%0b color=%0d shade=%0d,",
                     $time, results_seen, want.ray_length, want.hit_player,
                     want.hit_color, want.shade,
                     " got len=%0d hit=%0b color=%0d shade=%0d",
                     got.ray_length, got.hit_player, got.hit_color, got.shade);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int r0, c0;
    for (int i = 0; i < GRID_SIDE * GRID_SIDE; i++) map_store[i] = 5'd0;
    max_steps_reg = DEF_MAX_STEPS;
    player_color_reg = DEF_PLAYER_COLOR;
    shade_step_reg = DEF_SHADE_STEP;

    // directed scene on reset register values
    add_write(0, 0, TYPE_WALL, 7);
    add_write(63, 63, TYPE_RESERVED, 3);
    add_write(10, 20, TYPE_WALL, 5);
    add_write(20, 14, TYPE_MIRROR, 2);
    add_write(40, 30, TYPE_MIRROR, 4);
    add_write(39, 30, TYPE_MIRROR, 6);
    // straight into a wall
    add_cast(cell_center(15), cell_center(10), ONE, 0);
    // straight into a mirror and back home
    add_cast(cell_center(10), cell_center(20), ONE, 0);
    // vertical into a mirror, side cell is the current cell
    add_cast(cell_center(14), cell_center(17), 0, ONE);
    // reserved type stops the ray; a wall in the map corner stops the next
    add_cast(cell_center(58), cell_center(63), ONE, 0);
    add_cast(cell_center(5), cell_center(0), -ONE, 0);
    // diagonal mirror hits: side cell mirror, then side cell void
    add_cast(cell_center(28), cell_center(38), DIAG, DIAG);
    add_cast(cell_center(28), cell_center(42), DIAG, -DIAG);
    // zero and tiny directions run to the step limit
    add_cast(cell_center(5), cell_center(5), 0, 0);
    add_cast(cell_center(5), cell_center(5), 1, -1);
    // map edges and extreme directions
    add_cast(20'd0, 20'd0, -1, -1);
    add_cast(20'hFFFFF, 20'hFFFFF, 32767, 32767);
    add_cast(cell_center(32), cell_center(32), -32768, -32768);
    add_cast(cell_center(32), cell_center(32), 16384, -16384);
    // clear the mirror and cast through to the edge
    add_write(20, 14, TYPE_VOID, 0);
    add_cast(cell_center(10), cell_center(20), ONE, 0);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    wait_drained();

    // top extremes of the step limit and player color, smallest nonzero shade step
    set_reg(CFG_MAX_STEPS, 8'd255);
    set_reg(CFG_PLAYER_COLOR, 8'd7);
    set_reg(CFG_SHADE_STEP, 8'd1);
    add_write(20, 14, TYPE_MIRROR, 1);
    add_cast(cell_center(10), cell_center(20), ONE, 0);
    add_cast(cell_center(5), cell_center(5), 0, 0);
    add_cast(cell_center(1), cell_center(33), ONE, 0);
    add_cast(cell_center(28), cell_center(38), DIAG, DIAG);
    wait_drained();

    // zero step limit and zero shade step
    set_reg(CFG_MAX_STEPS, 8'd0);
    set_reg(CFG_SHADE_STEP, 8'd0);
    set_reg(CFG_PLAYER_COLOR, 8'd0);
    add_cast(cell_center(15), cell_center(10), ONE, 0);
    add_cast(cell_center(5), cell_center(0), -ONE, 0);
    wait_drained();

    // one-step limit, widest shade step, zero shade with length
    set_reg(CFG_MAX_STEPS, 8'd1);
    set_reg(CFG_SHADE_STEP, 8'd255);
    add_cast(cell_center(13), cell_center(20), ONE, 0);
    add_cast(cell_center(5), cell_center(5), 0, ONE);
    wait_drained();
    set_reg(CFG_MAX_STEPS, 8'd30);
    set_reg(CFG_SHADE_STEP, 8'd0);
    add_cast(cell_center(5), cell_center(5), 0, 0);
    wait_drained();

    // random phases, each under its own register setting
    for (int ph = 0; ph < 6; ph++) begin
      set_reg(CFG_MAX_STEPS, ($urandom_range(0, 3) == 0) ? 8'($urandom_range(100, 255))
                                                         : 8'($urandom_range(1, 60)));
      set_reg(CFG_PLAYER_COLOR, 8'($urandom));
      set_reg(CFG_SHADE_STEP, ($urandom_range(0, 3) == 0) ? 8'($urandom_range(20, 255))
                                                          : 8'($urandom_range(1, 12)));
      r0 = $urandom_range(0, GRID_SIDE - 1);
      c0 = $urandom_range(0, GRID_SIDE - 1);
      if (ph == 2) hold_request = 1;
      for (int n = 0; n < 62; n++) begin
        add_random_item(r0, c0);
        if ($urandom_range(0, 19) == 0) begin
          r0 = $urandom_range(0, GRID_SIDE - 1);
          c0 = $urandom_range(0, GRID_SIDE - 1);
        end
      end
      wait_drained();
    end

    $display("%0d cell writes and %0d casts over %0d register settings",
             writes_taken, casts_taken, phases_run);
    $display("%0d rays bounced off mirrors, %0d came back to the start cell, %0d mismatches",
             bounced_rays, player_hits, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[grid_ray_march_with_mirrors_top.f]
+incdir+rtl/core
rtl/core/grmm_pkg.sv
rtl/core/grmm_map_ram.sv
rtl/core/grmm_engine.sv
rtl/core/grid_ray_march_with_mirrors_top.sv
dv/testbench.sv
